@@ hw/rtl/lkv_pkg.sv @@
// shared types and constants for the lfu key/value cache
// no dependencies; used by lkv_store, lkv_scan and lfu_key_value_cache
package lkv_pkg;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W   = 5;

  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0]   CNT_SAT   = 32'hFFFF_FFFF;
  localparam logic [STAMP_W-1:0] STAMP_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } rsp_t;

  // one stored slot, valid flag kept apart in flops
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   use_count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic match_found;
    logic victim_found;
    logic free_found;
  } scan_flags_t;

endpackage

@@ hw/rtl/lkv_store.sv @@
// slot memory (one read, one write port, registered read) plus valid flags
// depends on lkv_pkg
module lkv_store #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output lkv_pkg::entry_t    rd_data,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  lkv_pkg::entry_t    wr_data,
  input  logic               vld_clr,
  input  logic [IDX_W-1:0]   vld_clr_idx,
  input  logic               vld_set,
  input  logic [IDX_W-1:0]   vld_set_idx,
  output logic [ENTRIES-1:0] valid
);

  lkv_pkg::entry_t    mem [ENTRIES];
  logic [ENTRIES-1:0] valid_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // set after clear so a slot evicted and refilled at once ends valid
  always_comb begin
    valid_next = valid;
    if (vld_clr) begin
      valid_next[vld_clr_idx] = 1'b0;
    end
    if (vld_set) begin
      valid_next[vld_set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

@@ hw/rtl/lkv_scan.sv @@
// per-slot compare during the sweep: key match, lfu victim, first free slot
// depends on lkv_pkg
module lkv_scan #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                          clk,
  input  logic                          clear,
  input  logic                          in_valid,
  input  logic [IDX_W-1:0]              idx,
  input  logic                          slot_valid,
  input  lkv_pkg::entry_t               entry,
  input  logic [lkv_pkg::KEY_W-1:0]     key,
  output lkv_pkg::scan_flags_t          flags,
  output logic [IDX_W-1:0]              match_idx,
  output lkv_pkg::entry_t               match_entry,
  output logic [IDX_W-1:0]              victim_idx,
  output logic [IDX_W-1:0]              free_idx
);

  logic [lkv_pkg::CNT_W-1:0]   victim_cnt;
  logic [lkv_pkg::STAMP_W-1:0] victim_stamp;
  logic                        older;

  // strict compare keeps the lowest index on a full tie
  assign older = (entry.use_count < victim_cnt) ||
                 ((entry.use_count == victim_cnt) && (entry.stamp < victim_stamp));

  always_ff @(posedge clk) begin
    if (clear) begin
      flags <= '0;
    end else if (in_valid) begin
      if (slot_valid) begin
        if (!flags.match_found && (entry.key == key)) begin
          flags.match_found <= 1'b1;
          match_idx         <= idx;
          match_entry       <= entry;
        end
        if (!flags.victim_found || older) begin
          flags.victim_found <= 1'b1;
          victim_idx         <= idx;
          victim_cnt         <= entry.use_count;
          victim_stamp       <= entry.stamp;
        end
      end else if (!flags.free_found) begin
        flags.free_found <= 1'b1;
        free_idx         <= idx;
      end
    end
  end

endmodule

@@ hw/rtl/lfu_key_value_cache.sv @@
// lfu key/value cache with oldest-stamp tiebreak, sweeping one slot per cycle
// one item at a time: busy is high from the accepting edge until done rises;
// the sweep reads each slot through the single read port of the slot memory,
// then drains and writes. with capacity 0 done is registered at the accepting edge
// reset: synchronous, clears valid flags, occupancy, access clock and
// capacity (to 16). results are strobed for one cycle; no stall from the receiver
module lfu_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  lkv_pkg::req_t               item,
  output logic                        done,
  output lkv_pkg::rsp_t               result,
  input  logic                        cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CW    = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    WRITE
  } state_t;

  state_t                        state;
  logic [lkv_pkg::CAP_W-1:0]     capacity;
  logic [OCC_W-1:0]              occ;
  logic [lkv_pkg::STAMP_W-1:0]   access_clock;
  lkv_pkg::req_t                 req;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              rd_idx;
  logic                          rd_pend;

  logic [ENTRIES-1:0]            valid;
  lkv_pkg::entry_t               rd_data;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  lkv_pkg::entry_t               wr_data;
  logic                          vld_clr;
  logic                          vld_set;
  logic [IDX_W-1:0]              ins_idx;

  lkv_pkg::scan_flags_t          flags;
  logic [IDX_W-1:0]              match_idx;
  lkv_pkg::entry_t               match_entry;
  logic [IDX_W-1:0]              victim_idx;
  logic [IDX_W-1:0]              free_idx;

  logic [CW-1:0]                 cap_ext;
  logic [CW-1:0]                 cap_lim;
  logic                          need_evict;
  logic                          do_evict;
  logic                          do_insert;
  logic                          accept;
  logic [lkv_pkg::STAMP_W-1:0]   clock_next;
  logic [lkv_pkg::CNT_W-1:0]     count_next;
  logic                          done_next;
  lkv_pkg::rsp_t                 result_next;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;

  assign cap_ext = CW'(capacity);
  assign cap_lim = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;

  assign clock_next = (access_clock == lkv_pkg::STAMP_SAT) ? access_clock
                                                           : access_clock + 1'b1;
  assign count_next = (match_entry.use_count == lkv_pkg::CNT_SAT)
                      ? match_entry.use_count : match_entry.use_count + 1'b1;

  assign need_evict = (CW'(occ) >= cap_lim);
  assign do_evict   = (req.cmd == lkv_pkg::CMD_PUT) && !flags.match_found &&
                      need_evict && flags.victim_found;
  // evicted slot joins the free pool, lowest index wins
  assign ins_idx    = (do_evict && (!flags.free_found || (victim_idx < free_idx)))
                      ? victim_idx : free_idx;
  assign do_insert  = (req.cmd == lkv_pkg::CMD_PUT) && !flags.match_found &&
                      (do_evict || flags.free_found);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = match_idx;
    wr_data = match_entry;
    vld_clr = 1'b0;
    vld_set = 1'b0;
    if (state == WRITE) begin
      if (flags.match_found) begin
        wr_en             = 1'b1;
        wr_data.use_count = count_next;
        wr_data.stamp     = clock_next;
        if (req.cmd == lkv_pkg::CMD_PUT) begin
          wr_data.value = req.write_value;
        end
      end else if (do_insert) begin
        wr_en             = 1'b1;
        wr_addr           = ins_idx;
        wr_data.key       = req.lookup_key;
        wr_data.value     = req.write_value;
        wr_data.use_count = lkv_pkg::CNT_W'(1);
        wr_data.stamp     = clock_next;
        vld_clr           = do_evict;
        vld_set           = 1'b1;
      end
    end
  end

  // result strobe: straight from idle when disabled, else at the end of the sweep
  always_comb begin
    done_next   = 1'b0;
    result_next = result;
    if (state == IDLE) begin
      if (accept && (cap_lim == '0)) begin
        done_next   = 1'b1;
        result_next = '0;
      end
    end else if (state == WRITE) begin
      done_next   = 1'b1;
      result_next = '0;
      if (flags.match_found) begin
        if (req.cmd == lkv_pkg::CMD_GET) begin
          result_next.hit        = 1'b1;
          result_next.read_value = match_entry.value;
        end
      end else if (do_insert) begin
        result_next.evicted = do_evict;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      capacity     <= lkv_pkg::CAP_RESET;
      occ          <= '0;
      access_clock <= '0;
      done         <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      done    <= done_next;
      result  <= result_next;
      rd_pend <= (state == SCAN);
      rd_idx  <= rd_addr;
      unique case (state)
        IDLE: begin
          if (accept) begin
            req     <= item;
            rd_addr <= '0;
            if (cap_lim != '0) begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          rd_addr <= rd_addr + 1'b1;
          if (rd_addr == IDX_W'(ENTRIES - 1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= WRITE;
        end
        WRITE: begin
          state <= IDLE;
          if (flags.match_found) begin
            access_clock <= clock_next;
          end else if (do_insert) begin
            access_clock <= clock_next;
            if (!do_evict) begin
              occ <= occ + 1'b1;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  lkv_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (state == SCAN),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .vld_clr    (vld_clr),
    .vld_clr_idx(victim_idx),
    .vld_set    (vld_set),
    .vld_set_idx(ins_idx),
    .valid      (valid)
  );

  lkv_scan #(
    .ENTRIES(ENTRIES)
  ) u_scan (
    .clk        (clk),
    .clear      (accept),
    .in_valid   (rd_pend),
    .idx        (rd_idx),
    .slot_valid (valid[rd_idx]),
    .entry      (rd_data),
    .key        (req.lookup_key),
    .flags      (flags),
    .match_idx  (match_idx),
    .match_entry(match_entry),
    .victim_idx (victim_idx),
    .free_idx   (free_idx)
  );

  // occupancy counter must track the valid flags exactly
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occ))
    else $error("occupancy count out of step with valid flags");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == IDLE))
    else $error("result strobed while busy");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> !result.evicted && (result.read_value == $past(match_entry.value)))
    else $error("get hit with eviction or wrong value");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (rst)
    (state == WRITE) && (req.cmd == lkv_pkg::CMD_PUT) && !flags.match_found
      |-> do_insert)
    else $error("put miss found no slot to fill");

  a_clock_advances: assert property (@(posedge clk) disable iff (rst)
    (state == WRITE) && wr_en && (access_clock != lkv_pkg::STAMP_SAT)
      |=> (access_clock == $past(access_clock) + 1'b1))
    else $error("access clock did not advance on a touch");

endmodule
